[rtl/obsu_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsu_pkg - oriented box support unit shared definitions
// Word formats, request and register codes, stage records and the
// saturation helpers used across the pipeline.
// ----------------------------------------------------------------------------
package obsu_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int WORD_BITS  = 32;
   localparam int FIELD_W    = 32;
   localparam int HALF_W     = 31;
   localparam int PROX_W     = 31;
   localparam int NUM_AXES   = 3;
   localparam int FACE_BEATS = 4;
   localparam int BEAT_W     = $clog2(FACE_BEATS);
   localparam int PROD_W     = WORD_BITS + FIELD_W;
   localparam int DOT_W      = PROD_W + 2;
   localparam int SUM_W      = WORD_BITS + 4;

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [FIELD_W-1:0]   field_type;
   typedef logic        [HALF_W-1:0]    half_type;
   typedef logic        [PROX_W-1:0]    prox_type;
   typedef logic signed [PROD_W-1:0]    prod_type;
   typedef logic signed [DOT_W-1:0]     dot_type;
   typedef logic signed [SUM_W-1:0]     sum_type;
   typedef logic        [BEAT_W-1:0]    beat_type;

   localparam word_type WORD_MAX   = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN   = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam prox_type PROX_MAX   = '1;
   localparam half_type HALF_RESET = half_type'(1 << FRAC_BITS);

   typedef enum logic [1:0] {
      OP_LOAD_AXIS     = 2'd0,
      OP_LOAD_ORIGIN   = 2'd1,
      OP_SUPPORT_POINT = 2'd2,
      OP_SUPPORT_FACE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CSR_HALF_X = 2'd0,
      CSR_HALF_Y = 2'd1,
      CSR_HALF_Z = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef enum logic [1:0] {
      KIND_LOAD,
      KIND_POINT,
      KIND_FACE
   } kind_type;

   typedef struct {
      word_type axes    [NUM_AXES][NUM_AXES];
      word_type extents [NUM_AXES][NUM_AXES];
      word_type origin  [NUM_AXES];
   } state_type;

   typedef struct {
      logic     valid;
      kind_type kind;
      prod_type ext_dp  [NUM_AXES][NUM_AXES];
      prod_type axis_dp [NUM_AXES][NUM_AXES];
   } prod_stage_type;

   typedef struct {
      logic     valid;
      kind_type kind;
      word_type origin [NUM_AXES];
      sum_type  t1     [NUM_AXES];
      sum_type  t2     [NUM_AXES];
      sum_type  t3     [NUM_AXES];
      word_type aux    [NUM_AXES];
      prox_type prox;
      logic [1:0] face_axis;
   } term_stage_type;

   function automatic word_type sat_prod(prod_type x);
      if (x > prod_type'(WORD_MAX)) return WORD_MAX;
      if (x < prod_type'(WORD_MIN)) return WORD_MIN;
      return word_type'(x);
   endfunction

   function automatic word_type sat_sum(sum_type x);
      if (x > sum_type'(WORD_MAX)) return WORD_MAX;
      if (x < sum_type'(WORD_MIN)) return WORD_MIN;
      return word_type'(x);
   endfunction

   function automatic field_type to_field(word_type w);
      logic signed [WORD_BITS+FIELD_W-1:0] wide;
      wide = w;
      return wide[FIELD_W-1:0];
   endfunction

endpackage

[rtl/obsu_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsu_ifs - oriented box support unit channels
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface obsu_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [1:0]          axis_sel;
   obsu_pkg::field_type vec_x;
   obsu_pkg::field_type vec_y;
   obsu_pkg::field_type vec_z;

   modport source (output valid, op, axis_sel, vec_x, vec_y, vec_z, input ready);
   modport sink   (input valid, op, axis_sel, vec_x, vec_y, vec_z, output ready);
endinterface

interface obsu_rsp_if;
   logic                valid;
   logic                ready;
   obsu_pkg::field_type pt_x;
   obsu_pkg::field_type pt_y;
   obsu_pkg::field_type pt_z;
   obsu_pkg::field_type aux_x;
   obsu_pkg::field_type aux_y;
   obsu_pkg::field_type aux_z;
   obsu_pkg::prox_type  proximity;
   logic [1:0]          face_axis;
   logic                last;

   modport source (output valid, pt_x, pt_y, pt_z, aux_x, aux_y, aux_z,
                   proximity, face_axis, last, input ready);
   modport sink   (input valid, pt_x, pt_y, pt_z, aux_x, aux_y, aux_z,
                   proximity, face_axis, last, output ready);
endinterface

interface obsu_csr_if;
   logic               valid;
   logic               ready;
   logic [1:0]         index;
   obsu_pkg::half_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[rtl/obsu_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsu_front - input stage and box state
// Registers the request, holds half sizes, axes, extents and translation,
// and forms the partial products for the dot products and extent rebuild.
// ----------------------------------------------------------------------------
module obsu_front (
   input  logic                     clock,
   input  logic                     reset,
   obsu_req_if.sink                 req_if,
   obsu_csr_if.sink                 csr_if,
   input  logic                     s2_ready,
   output obsu_pkg::prod_stage_type s1_out,
   output obsu_pkg::state_type      state
);
   import obsu_pkg::*;

   logic      in_valid_ff;
   op_type    in_op_ff;
   logic [1:0] in_sel_ff;
   field_type in_vec_ff [NUM_AXES];
   half_type  half_ff   [NUM_AXES];
   state_type state_ff;

   logic      adv;
   logic      accept;
   half_type  half_sel;
   word_type  word_in     [NUM_AXES];
   prod_type  extent_prod [NUM_AXES];
   word_type  extent_in   [NUM_AXES];

   assign adv           = in_valid_ff && s2_ready;
   assign req_if.ready  = !in_valid_ff || s2_ready;
   assign accept        = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;
   assign state         = state_ff;

   always_comb begin
      case (in_sel_ff)
         AXIS_X:  half_sel = half_ff[0];
         AXIS_Y:  half_sel = half_ff[1];
         AXIS_Z:  half_sel = half_ff[2];
         default: half_sel = '0;
      endcase
      for (int j = 0; j < NUM_AXES; j++) begin
         word_in[j]     = sat_prod(prod_type'(in_vec_ff[j]));
         extent_prod[j] = word_in[j] * signed'({1'b0, half_sel});
         extent_in[j]   = sat_prod(extent_prod[j] >>> FRAC_BITS);
      end
   end

   always_comb begin
      s1_out.valid = in_valid_ff;
      case (in_op_ff)
         OP_SUPPORT_POINT: s1_out.kind = KIND_POINT;
         OP_SUPPORT_FACE:  s1_out.kind = KIND_FACE;
         default:          s1_out.kind = KIND_LOAD;
      endcase
      for (int i = 0; i < NUM_AXES; i++) begin
         for (int j = 0; j < NUM_AXES; j++) begin
            s1_out.ext_dp[i][j]  = in_vec_ff[j] * state_ff.extents[i][j];
            s1_out.axis_dp[i][j] = in_vec_ff[j] * state_ff.axes[i][j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff      <= 1'b0;
         half_ff          <= '{default: HALF_RESET};
         state_ff.axes    <= '{default: '0};
         state_ff.extents <= '{default: '0};
         state_ff.origin  <= '{default: '0};
      end else begin
         if (req_if.ready) begin
            in_valid_ff <= req_if.valid;
         end
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_HALF_X: half_ff[0] <= csr_if.data;
               CSR_HALF_Y: half_ff[1] <= csr_if.data;
               CSR_HALF_Z: half_ff[2] <= csr_if.data;
               default: ;
            endcase
         end
         if (adv) begin
            case (in_op_ff)
               OP_LOAD_AXIS: begin
                  case (in_sel_ff)
                     AXIS_X: begin
                        state_ff.axes[0]    <= word_in;
                        state_ff.extents[0] <= extent_in;
                     end
                     AXIS_Y: begin
                        state_ff.axes[1]    <= word_in;
                        state_ff.extents[1] <= extent_in;
                     end
                     AXIS_Z: begin
                        state_ff.axes[2]    <= word_in;
                        state_ff.extents[2] <= extent_in;
                     end
                     default: ;
                  endcase
               end
               OP_LOAD_ORIGIN: state_ff.origin <= word_in;
               default: ;
            endcase
         end
      end
      if (accept) begin
         in_op_ff     <= op_type'(req_if.op);
         in_sel_ff    <= req_if.axis_sel;
         in_vec_ff[0] <= req_if.vec_x;
         in_vec_ff[1] <= req_if.vec_y;
         in_vec_ff[2] <= req_if.vec_z;
      end
   end

endmodule

[rtl/obsu_resolve.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsu_resolve - dot product stage
// Sums the registered partial products, takes extent signs for support
// points, picks the face axis, and lines up the terms for the output adder.
// ----------------------------------------------------------------------------
module obsu_resolve (
   input  logic                     clock,
   input  logic                     reset,
   input  obsu_pkg::prod_stage_type s1_in,
   input  obsu_pkg::state_type      state,
   output logic                     s2_ready,
   input  logic                     s3_ready,
   output obsu_pkg::term_stage_type s3_out
);
   import obsu_pkg::*;

   prod_stage_type p2_ff;

   dot_type  dot_e [NUM_AXES];
   dot_type  dot_a [NUM_AXES];
   dot_type  mag_a [NUM_AXES];
   dot_type  val_a [NUM_AXES];
   axis_type best;
   dot_type  best_val;
   logic     flip;
   word_type e_n [NUM_AXES];
   word_type e_u [NUM_AXES];
   word_type e_v [NUM_AXES];
   word_type a_n [NUM_AXES];
   sum_type  dv  [NUM_AXES];

   function automatic sum_type mag_word(word_type w);
      return w[WORD_BITS-1] ? -sum_type'(w) : sum_type'(w);
   endfunction

   function automatic sum_type signed_word(word_type w, logic neg);
      return neg ? -sum_type'(w) : sum_type'(w);
   endfunction

   assign s2_ready = !p2_ff.valid || s3_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_ff.valid <= 1'b0;
      end else if (s2_ready) begin
         p2_ff.valid <= s1_in.valid;
      end
      if (s2_ready && s1_in.valid) begin
         p2_ff.kind    <= s1_in.kind;
         p2_ff.ext_dp  <= s1_in.ext_dp;
         p2_ff.axis_dp <= s1_in.axis_dp;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         dot_e[i] = dot_type'(p2_ff.ext_dp[i][0]) + dot_type'(p2_ff.ext_dp[i][1])
                  + dot_type'(p2_ff.ext_dp[i][2]);
         dot_a[i] = dot_type'(p2_ff.axis_dp[i][0]) + dot_type'(p2_ff.axis_dp[i][1])
                  + dot_type'(p2_ff.axis_dp[i][2]);
         mag_a[i] = dot_a[i][DOT_W-1] ? -dot_a[i] : dot_a[i];
         val_a[i] = mag_a[i] >>> FRAC_BITS;
      end

      // first axis wins a tie
      best     = AXIS_X;
      best_val = val_a[0];
      if (val_a[1] > best_val) begin
         best     = AXIS_Y;
         best_val = val_a[1];
      end
      if (val_a[2] > best_val) begin
         best     = AXIS_Z;
         best_val = val_a[2];
      end

      case (best)
         AXIS_Y: begin
            flip = dot_a[1][DOT_W-1];
            e_n  = state.extents[1];
            e_u  = state.extents[2];
            e_v  = state.extents[0];
            a_n  = state.axes[1];
         end
         AXIS_Z: begin
            flip = dot_a[2][DOT_W-1];
            e_n  = state.extents[2];
            e_u  = state.extents[0];
            e_v  = state.extents[1];
            a_n  = state.axes[2];
         end
         default: begin
            flip = dot_a[0][DOT_W-1];
            e_n  = state.extents[0];
            e_u  = state.extents[1];
            e_v  = state.extents[2];
            a_n  = state.axes[0];
         end
      endcase

      s3_out.valid     = p2_ff.valid;
      s3_out.kind      = p2_ff.kind;
      s3_out.origin    = state.origin;
      s3_out.prox      = '0;
      s3_out.face_axis = '0;
      for (int j = 0; j < NUM_AXES; j++) begin
         dv[j] = mag_word(state.extents[0][j]) + mag_word(state.extents[1][j])
               + mag_word(state.extents[2][j]);
         s3_out.t1[j]  = '0;
         s3_out.t2[j]  = '0;
         s3_out.t3[j]  = '0;
         s3_out.aux[j] = '0;
      end

      case (p2_ff.kind)
         KIND_LOAD: begin
            for (int j = 0; j < NUM_AXES; j++) begin
               s3_out.t1[j]  = -dv[j];
               s3_out.aux[j] = sat_sum(sum_type'(state.origin[j]) + dv[j]);
            end
         end
         KIND_POINT: begin
            for (int j = 0; j < NUM_AXES; j++) begin
               s3_out.t1[j] = signed_word(state.extents[0][j], dot_e[0][DOT_W-1]);
               s3_out.t2[j] = signed_word(state.extents[1][j], dot_e[1][DOT_W-1]);
               s3_out.t3[j] = signed_word(state.extents[2][j], dot_e[2][DOT_W-1]);
            end
         end
         KIND_FACE: begin
            for (int j = 0; j < NUM_AXES; j++) begin
               s3_out.t1[j]  = signed_word(e_n[j], flip);
               s3_out.t2[j]  = signed_word(e_u[j], flip);
               s3_out.t3[j]  = sum_type'(e_v[j]);
               s3_out.aux[j] = sat_sum(signed_word(a_n[j], flip));
            end
            s3_out.prox      = (best_val > dot_type'(PROX_MAX)) ? PROX_MAX
                                                               : best_val[PROX_W-1:0];
            s3_out.face_axis = best;
         end
         default: ;
      endcase
   end

endmodule

[rtl/obsu_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsu_emit - response register
// Holds one request's terms and plays out its responses: one for loads and
// support points, four face vertices for a support-face request.
// ----------------------------------------------------------------------------
module obsu_emit (
   input  logic                     clock,
   input  logic                     reset,
   input  obsu_pkg::term_stage_type s3_in,
   output logic                     s3_ready,
   obsu_rsp_if.source               rsp_if
);
   import obsu_pkg::*;

   localparam beat_type LAST_BEAT = beat_type'(FACE_BEATS - 1);

   term_stage_type t_ff;
   beat_type       beat_ff;

   logic     last_beat;
   logic     done;
   logic     neg_u;
   logic     neg_v;
   word_type pt [NUM_AXES];

   assign last_beat = (t_ff.kind != KIND_FACE) || (beat_ff == LAST_BEAT);
   assign done      = t_ff.valid && rsp_if.ready && last_beat;
   assign s3_ready  = !t_ff.valid || done;

   // vertex order: +u+v, +u-v, -u-v, -u+v
   assign neg_u = (t_ff.kind == KIND_FACE) && beat_ff[1];
   assign neg_v = (t_ff.kind == KIND_FACE) && (beat_ff[1] ^ beat_ff[0]);

   always_comb begin
      for (int j = 0; j < NUM_AXES; j++) begin
         pt[j] = sat_sum(sum_type'(t_ff.origin[j]) + t_ff.t1[j]
                       + (neg_u ? -t_ff.t2[j] : t_ff.t2[j])
                       + (neg_v ? -t_ff.t3[j] : t_ff.t3[j]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t_ff.valid <= 1'b0;
         beat_ff    <= '0;
      end else begin
         if (s3_ready) begin
            t_ff.valid <= s3_in.valid;
         end
         if (t_ff.valid && rsp_if.ready) begin
            beat_ff <= last_beat ? '0 : beat_ff + beat_type'(1);
         end
      end
      if (s3_ready && s3_in.valid) begin
         t_ff.kind      <= s3_in.kind;
         t_ff.origin    <= s3_in.origin;
         t_ff.t1        <= s3_in.t1;
         t_ff.t2        <= s3_in.t2;
         t_ff.t3        <= s3_in.t3;
         t_ff.aux       <= s3_in.aux;
         t_ff.prox      <= s3_in.prox;
         t_ff.face_axis <= s3_in.face_axis;
      end
   end

   assign rsp_if.valid     = t_ff.valid;
   assign rsp_if.pt_x      = to_field(pt[0]);
   assign rsp_if.pt_y      = to_field(pt[1]);
   assign rsp_if.pt_z      = to_field(pt[2]);
   assign rsp_if.aux_x     = to_field(t_ff.aux[0]);
   assign rsp_if.aux_y     = to_field(t_ff.aux[1]);
   assign rsp_if.aux_z     = to_field(t_ff.aux[2]);
   assign rsp_if.proximity = t_ff.prox;
   assign rsp_if.face_axis = t_ff.face_axis;
   assign rsp_if.last      = last_beat;

endmodule

[rtl/oriented_box_support_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oriented_box_support_unit - oriented box support mapping, Q16.16
// Three-stage pipeline: request register with box state and multipliers,
// dot product and axis selection, response register with vertex adder.
// ----------------------------------------------------------------------------
// One request is taken per cycle unless stalled. Its first response is
// presented once the request has passed the request register, the dot-product
// register and the response register. Load and support-point requests give
// one response each and sustain one request per cycle while rsp_if.ready is
// high. A support-face request gives four consecutive responses and holds the
// response register until its last vertex is taken; meanwhile the two stages
// ahead of it each take one more request and then stall. Rate is set by the
// response register: one response per cycle while rsp_if.ready is high. Axis
// and translation loads update the box state as they leave the first stage
// and answer with the axis-aligned bounds. Half sizes written over the
// register port take effect on an axis only when that axis is next loaded.
// req_if.ready follows rsp_if.ready combinationally through the pipeline.
// ----------------------------------------------------------------------------
module oriented_box_support_unit (
   input  logic       clock,
   input  logic       reset,
   obsu_req_if.sink   req_if,
   obsu_rsp_if.source rsp_if,
   obsu_csr_if.sink   csr_if
);
   import obsu_pkg::*;

   prod_stage_type s1;
   state_type      st;
   term_stage_type s2;
   logic           s2_ready;
   logic           s3_ready;

   obsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_if   (req_if),
      .csr_if   (csr_if),
      .s2_ready (s2_ready),
      .s1_out   (s1),
      .state    (st)
   );

   obsu_resolve u_resolve (
      .clock    (clock),
      .reset    (reset),
      .s1_in    (s1),
      .state    (st),
      .s2_ready (s2_ready),
      .s3_ready (s3_ready),
      .s3_out   (s2)
   );

   obsu_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .s3_in    (s2),
      .s3_ready (s3_ready),
      .rsp_if   (rsp_if)
   );

endmodule

[rtl/obsu_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// obsu_checker - response channel checks
// Watches the response ports: held responses, face runs and reset.
// ----------------------------------------------------------------------------
module obsu_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input obsu_pkg::field_type pt_x,
   input obsu_pkg::field_type pt_y,
   input obsu_pkg::field_type pt_z,
   input obsu_pkg::field_type aux_x,
   input obsu_pkg::field_type aux_y,
   input obsu_pkg::field_type aux_z,
   input obsu_pkg::prox_type  proximity,
   input logic [1:0]          face_axis,
   input logic                rsp_last
);
   import obsu_pkg::*;

   localparam beat_type RUN_MAX = beat_type'(FACE_BEATS - 1);

   beat_type run_ff;
   logic     rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (rsp_fire) begin
         run_ff <= rsp_last ? '0 : run_ff + beat_type'(1);
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pt_x) && $stable(pt_y)
         && $stable(pt_z) && $stable(aux_x) && $stable(aux_y) && $stable(aux_z)
         && $stable(proximity) && $stable(face_axis) && $stable(rsp_last))
      else $error("response changed while stalled");

   a_face_run: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last |=> rsp_valid && $stable(face_axis) && $stable(proximity)
         && $stable(aux_x) && $stable(aux_y) && $stable(aux_z))
      else $error("face vertices disagree on axis, normal or proximity");

   a_run_length: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_last |-> run_ff != RUN_MAX)
      else $error("face run longer than four responses");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind oriented_box_support_unit obsu_checker u_obsu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .pt_x      (rsp_if.pt_x),
   .pt_y      (rsp_if.pt_y),
   .pt_z      (rsp_if.pt_z),
   .aux_x     (rsp_if.aux_x),
   .aux_y     (rsp_if.aux_y),
   .aux_z     (rsp_if.aux_z),
   .proximity (rsp_if.proximity),
   .face_axis (rsp_if.face_axis),
   .rsp_last  (rsp_if.last)
);
